/* src/kfc_pkg.sv */
// ---------------------------------------------------------------------------
// kfc_pkg
// shared types, constants and saturating helpers for the keypad calculator
// ---------------------------------------------------------------------------
package kfc_pkg;

   localparam int FRAC_BITS       = 24;
   localparam int MAX_FRAC_DIGITS = 7;
   localparam int MUL_STEPS       = 64;
   localparam int DIV_W           = 64 + FRAC_BITS;
   localparam int DIV_STEPS       = DIV_W;
   localparam int CNT_W           = $clog2(DIV_STEPS);

   localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAX_POS  = 64'h7FFF_FFFF_FFFF_FFFF;

   localparam logic [63:0] POW_TEN [10] = '{
      64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000,
      64'd10000000, 64'd100000000, 64'd1000000000
   };

   typedef enum logic [2:0] {
      CMD_DIGIT    = 3'd0,
      CMD_POINT    = 3'd1,
      CMD_ADD      = 3'd2,
      CMD_SUBTRACT = 3'd3,
      CMD_MULTIPLY = 3'd4,
      CMD_DIVIDE   = 3'd5,
      CMD_EQUALS   = 3'd6,
      CMD_CLEAR    = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      PEND_NONE = 3'd0,
      PEND_ADD  = 3'd1,
      PEND_SUB  = 3'd2,
      PEND_MUL  = 3'd3,
      PEND_DIV  = 3'd4
   } pend_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_DIV_ZERO = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type    command;
      logic [3:0] digit;
   } req_word_type;

   typedef struct packed {
      logic signed [63:0] display_value;
      status_type         status;
   } rsp_word_type;

   typedef enum logic [2:0] {
      S_IDLE, S_INT_ADD, S_MUL, S_MUL_END, S_DIV, S_DIV_END, S_FINISH
   } ctrl_state_type;

   typedef enum logic [2:0] {
      DP_NONE, DP_START, DP_DIGIT_ADD, DP_MUL_STEP, DP_MUL_END, DP_DIV_STEP, DP_DIV_END
   } dp_op_type;

   typedef enum logic [1:0] {
      KIND_SIMPLE, KIND_INT_DIGIT, KIND_MUL, KIND_DIV
   } work_kind_type;

   typedef struct packed {
      dp_op_type op;
      logic      rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      work_kind_type kind;
   } dp_status_type;

   // returns {overflow, value}
   function automatic logic [64:0] add_sat(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (((a ^ b) & SIGN_BIT) == '0 && ((a ^ s) & SIGN_BIT) != '0)
         return {1'b1, (a[63] ? SIGN_BIT : MAX_POS)};
      return {1'b0, s};
   endfunction

   function automatic logic [64:0] sub_sat(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a - b;
      if (((a ^ b) & SIGN_BIT) != '0 && ((a ^ s) & SIGN_BIT) != '0)
         return {1'b1, (a[63] ? SIGN_BIT : MAX_POS)};
      return {1'b0, s};
   endfunction

   // magnitude plus sign to saturated two's complement
   function automatic logic [64:0] sat_mag(input logic [63:0] lo, input logic over,
                                           input logic neg);
      if (neg) begin
         if (over || lo > SIGN_BIT) return {1'b1, SIGN_BIT};
         return {1'b0, (~lo + 64'd1)};
      end
      if (over || lo[63]) return {1'b1, MAX_POS};
      return {1'b0, lo};
   endfunction

endpackage

/* src/kfc_dp.sv */
// ---------------------------------------------------------------------------
// kfc_dp
// calculator datapath: entry state, shift-add multiplier, restoring divider
// ---------------------------------------------------------------------------
module kfc_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  kfc_pkg::req_word_type req_word,
   input  kfc_pkg::ctrl_cmd_type ctrl_cmd,
   output kfc_pkg::dp_status_type dp_status,
   output kfc_pkg::rsp_word_type rsp_word
);
   import kfc_pkg::*;

   logic [63:0] entry_ff, entry_in, operand_ff, operand_in;
   pend_type    pend_ff, pend_in;
   logic [3:0]  pos_ff, pos_in;
   status_type  st_ff, st_in;
   logic [3:0]  digit_ff, digit_in;
   logic [63:0] tmp_ff, tmp_in;
   logic        neg_ff, neg_in;
   logic [63:0] mcand_ff, mcand_in, acc_hi_ff, acc_hi_in, acc_lo_ff, acc_lo_in;
   logic [63:0] div_d_ff, div_d_in, rem_ff, rem_in;
   logic [DIV_W-1:0] num_ff, num_in;
   rsp_word_type rsp_word_ff;

   logic [63:0]  inc_tab [10][10];
   logic [63:0]  mag_e, mag_o;
   logic [67:0]  mag10;
   logic [64:0]  res;
   logic [64:0]  msum, r2;
   logic         ge;
   logic [127:0] prod_sh;

   // rounded fraction digit weights, built at elaboration
   for (genvar gk = 0; gk < 10; gk++) begin : g_k
      for (genvar gd = 0; gd < 10; gd++) begin : g_d
         localparam logic [63:0] INC =
            ((64'(gd) << FRAC_BITS) + POW_TEN[gk] / 2) / POW_TEN[gk];
         assign inc_tab[gk][gd] = INC;
      end
   end

   assign mag_e   = entry_ff[63] ? (~entry_ff + 64'd1) : entry_ff;
   assign mag_o   = operand_ff[63] ? (~operand_ff + 64'd1) : operand_ff;
   assign mag10   = ({4'b0, mag_e} << 3) + ({4'b0, mag_e} << 1);
   assign msum    = {1'b0, acc_hi_ff} + {1'b0, (acc_lo_ff[0] ? mcand_ff : 64'd0)};
   assign r2      = {rem_ff, num_ff[DIV_W-1]};
   assign ge      = r2 >= {1'b0, div_d_ff};
   assign prod_sh = {acc_hi_ff, acc_lo_ff} >> FRAC_BITS;

   always_comb begin
      if (req_word.command == CMD_DIGIT && req_word.digit <= 4'd9 && pos_ff == '0)
         dp_status.kind = KIND_INT_DIGIT;
      else if (req_word.command == CMD_EQUALS && pend_ff == PEND_MUL)
         dp_status.kind = KIND_MUL;
      else if (req_word.command == CMD_EQUALS && pend_ff == PEND_DIV && entry_ff != '0)
         dp_status.kind = KIND_DIV;
      else
         dp_status.kind = KIND_SIMPLE;
   end

   always_comb begin
      entry_in   = entry_ff;
      operand_in = operand_ff;
      pend_in    = pend_ff;
      pos_in     = pos_ff;
      st_in      = st_ff;
      digit_in   = digit_ff;
      tmp_in     = tmp_ff;
      neg_in     = neg_ff;
      mcand_in   = mcand_ff;
      acc_hi_in  = acc_hi_ff;
      acc_lo_in  = acc_lo_ff;
      div_d_in   = div_d_ff;
      rem_in     = rem_ff;
      num_in     = num_ff;
      res        = '0;
      unique case (ctrl_cmd.op)
         DP_START: begin
            st_in    = ST_OK;
            digit_in = req_word.digit;
            neg_in   = operand_ff[63] ^ entry_ff[63];
            unique case (req_word.command)
               CMD_DIGIT: begin
                  if (req_word.digit <= 4'd9) begin
                     if (pos_ff == '0) begin
                        // entry times ten, saturated; digit follows next cycle
                        res    = sat_mag(mag10[63:0], |mag10[67:64], entry_ff[63]);
                        tmp_in = res[63:0];
                        st_in  = res[64] ? ST_OVERFLOW : ST_OK;
                     end else if (pos_ff <= 4'(MAX_FRAC_DIGITS)) begin
                        res      = add_sat(entry_ff, inc_tab[pos_ff][req_word.digit]);
                        entry_in = res[63:0];
                        st_in    = res[64] ? ST_OVERFLOW : ST_OK;
                        pos_in   = pos_ff + 4'd1;
                     end
                  end
               end
               CMD_POINT: begin
                  if (pos_ff == '0) pos_in = 4'd1;
               end
               CMD_ADD, CMD_SUBTRACT, CMD_MULTIPLY, CMD_DIVIDE: begin
                  unique case (req_word.command)
                     CMD_ADD:      pend_in = PEND_ADD;
                     CMD_SUBTRACT: pend_in = PEND_SUB;
                     CMD_MULTIPLY: pend_in = PEND_MUL;
                     default:      pend_in = PEND_DIV;
                  endcase
                  operand_in = entry_ff;
                  entry_in   = '0;
                  pos_in     = '0;
               end
               CMD_EQUALS: begin
                  pend_in = PEND_NONE;
                  pos_in  = '0;
                  unique case (pend_ff)
                     PEND_ADD: begin
                        res      = add_sat(operand_ff, entry_ff);
                        entry_in = res[63:0];
                        st_in    = res[64] ? ST_OVERFLOW : ST_OK;
                     end
                     PEND_SUB: begin
                        res      = sub_sat(operand_ff, entry_ff);
                        entry_in = res[63:0];
                        st_in    = res[64] ? ST_OVERFLOW : ST_OK;
                     end
                     PEND_MUL: begin
                        mcand_in  = mag_o;
                        acc_hi_in = '0;
                        acc_lo_in = mag_e;
                     end
                     PEND_DIV: begin
                        if (entry_ff == '0) st_in = ST_DIV_ZERO;
                        else begin
                           div_d_in = mag_e;
                           rem_in   = '0;
                           num_in   = {mag_o, {FRAC_BITS{1'b0}}};
                        end
                     end
                     default: ;
                  endcase
               end
               default: begin
                  entry_in   = '0;
                  operand_in = '0;
                  pend_in    = PEND_NONE;
                  pos_in     = '0;
               end
            endcase
         end
         DP_DIGIT_ADD: begin
            if (st_ff == ST_OK) begin
               res      = add_sat(tmp_ff, 64'(digit_ff) << FRAC_BITS);
               entry_in = res[63:0];
               st_in    = res[64] ? ST_OVERFLOW : ST_OK;
            end else entry_in = tmp_ff;
         end
         DP_MUL_STEP: begin
            acc_hi_in = msum[64:1];
            acc_lo_in = {msum[0], acc_lo_ff[63:1]};
         end
         DP_MUL_END: begin
            res      = sat_mag(prod_sh[63:0], |prod_sh[127:64], neg_ff);
            entry_in = res[63:0];
            st_in    = res[64] ? ST_OVERFLOW : ST_OK;
         end
         DP_DIV_STEP: begin
            rem_in = ge ? 64'(r2 - {1'b0, div_d_ff}) : r2[63:0];
            num_in = {num_ff[DIV_W-2:0], ge};
         end
         DP_DIV_END: begin
            res      = sat_mag(num_ff[63:0], |num_ff[DIV_W-1:64], neg_ff);
            entry_in = res[63:0];
            st_in    = res[64] ? ST_OVERFLOW : ST_OK;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff   <= '0;
         operand_ff <= '0;
         pend_ff    <= PEND_NONE;
         pos_ff     <= '0;
         st_ff      <= ST_OK;
      end else begin
         entry_ff   <= entry_in;
         operand_ff <= operand_in;
         pend_ff    <= pend_in;
         pos_ff     <= pos_in;
         st_ff      <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff  <= digit_in;
      tmp_ff    <= tmp_in;
      neg_ff    <= neg_in;
      mcand_ff  <= mcand_in;
      acc_hi_ff <= acc_hi_in;
      acc_lo_ff <= acc_lo_in;
      div_d_ff  <= div_d_in;
      rem_ff    <= rem_in;
      num_ff    <= num_in;
      if (ctrl_cmd.rsp_load) begin
         rsp_word_ff.display_value <= entry_ff;
         rsp_word_ff.status        <= st_ff;
      end
   end

   assign rsp_word = rsp_word_ff;

endmodule

/* src/kfc_ctrl.sv */
// ---------------------------------------------------------------------------
// kfc_ctrl
// sequencer for one key word: start, iteration count, result handoff
// ---------------------------------------------------------------------------
module kfc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  kfc_pkg::dp_status_type dp_status,
   output kfc_pkg::ctrl_cmd_type  ctrl_cmd
);
   import kfc_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in          = state_ff;
      cnt_in            = cnt_ff;
      ctrl_cmd.op       = DP_NONE;
      ctrl_cmd.rsp_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (req_valid) begin
               ctrl_cmd.op = DP_START;
               unique case (dp_status.kind)
                  KIND_INT_DIGIT: state_in = S_INT_ADD;
                  KIND_MUL:       state_in = S_MUL;
                  KIND_DIV:       state_in = S_DIV;
                  default:        state_in = S_FINISH;
               endcase
            end
         end
         S_INT_ADD: begin
            ctrl_cmd.op = DP_DIGIT_ADD;
            state_in    = S_FINISH;
         end
         S_MUL: begin
            ctrl_cmd.op = DP_MUL_STEP;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MUL_STEPS - 1)) state_in = S_MUL_END;
         end
         S_MUL_END: begin
            ctrl_cmd.op = DP_MUL_END;
            state_in    = S_FINISH;
         end
         S_DIV: begin
            ctrl_cmd.op = DP_DIV_STEP;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) state_in = S_DIV_END;
         end
         S_DIV_END: begin
            ctrl_cmd.op = DP_DIV_END;
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               ctrl_cmd.rsp_load = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = ctrl_cmd.rsp_load | (rsp_valid_ff & rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign req_stall    = (state_ff != S_IDLE);

endmodule

/* src/keypad_four_function_calculator.sv */
// ---------------------------------------------------------------------------
// keypad_four_function_calculator
// four-function fixed point calculator driven by one key word at a time
// ---------------------------------------------------------------------------
// usage
//   req channel: one key word (command, digit) per handshake; req_stall is
//   high while a key is being worked on, so one key is in flight at a time
//   rsp channel: one word per key, the value on show and a status code
//   work from accept to rsp_valid, by key:
//     point, operator, clear, fraction digit, add/subtract equals: done at start
//     integer digit: times ten, then digit add
//     multiply equals: 64 shift-add steps of one 64-bit adder
//     divide equals: restoring divide, one quotient bit per cycle
//   the iterative multiplier and divider set the worst case rate
//   the output register holds a finished word while rsp_stall is high; the
//   next key is worked on meanwhile and waits only for its own handoff
//   reset (synchronous, active high) clears entry, operand, pending
//   operation, fraction position and any word not yet taken
// ---------------------------------------------------------------------------
module keypad_four_function_calculator (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  kfc_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output kfc_pkg::rsp_word_type rsp_word
);
   import kfc_pkg::*;

   // command from the sequencer, status back from the datapath
   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   kfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_status (dp_status),
      .ctrl_cmd  (ctrl_cmd)
   );

   kfc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .ctrl_cmd  (ctrl_cmd),
      .dp_status (dp_status),
      .rsp_word  (rsp_word)
   );

endmodule
